// ===== sv/cedb_pkg.sv =====
// Shared types and constants of the CIGAR and edit distance builder.
// Holds payload structs, operation codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package cedb_pkg;

    // CIGAR operation codes as they appear on the result channel.
    typedef enum logic [1:0] {
        OP_M = 2'd0,
        OP_I = 2'd1,
        OP_D = 2'd2,
        OP_S = 2'd3
    } op_code_t;

    // Configuration register indexes.
    localparam logic [7:0] CFG_LEFT_PRIMER  = 8'd0;
    localparam logic [7:0] CFG_RIGHT_PRIMER = 8'd1;

    typedef struct packed {
        logic       query_gap;
        logic       ref_gap;
        logic [7:0] query_base;
        logic [7:0] ref_base;
        logic       last_column;
    } column_t;

    typedef struct packed {
        logic [1:0]  op_code;
        logic [15:0] op_length;
        logic [15:0] edit_distance;
        logic [15:0] mismatch_count;
        logic        skipped;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] data;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_PREP,
        ST_WIN,
        ST_DECIDE,
        ST_SL,
        ST_FM,
        ST_SM,
        ST_MID,
        ST_LM,
        ST_SR,
        ST_SUM,
        ST_SKIP
    } state_t;

    // Which result the datapath builds when the controller loads the output.
    typedef enum logic [2:0] {
        EMIT_SL,
        EMIT_FM,
        EMIT_SM,
        EMIT_MID,
        EMIT_LM,
        EMIT_SR,
        EMIT_SUM,
        EMIT_SKIP
    } emit_sel_t;

    typedef struct packed {
        logic      col_accept;
        logic      win_start;
        logic      win_step;
        logic      latch_dec;
        logic      idx_inc;
        logic      out_load;
        emit_sel_t emit_sel;
        logic      clear_align;
    } ctrl_cmd_t;

    typedef struct packed {
        logic win_done;
        logic dec_skip;
        logic single;
        logic first_m;
        logic last_m;
        logic mid_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/cedb_chan_if.sv =====
// Valid/ready channel used for the column, result and configuration ports.
// The payload type is set per instance; depends on nothing else.
interface cedb_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/cigar_edit_distance_builder_unit.sv =====
// CIGAR and edit distance builder, top level.
// Depends on cedb_pkg, cedb_chan_if, cedb_ctrl and cedb_dp (with cedb_ram).
//
// Usage:
//   col carries one alignment column per transaction (gap flags, two bases,
//   last_column). Columns are taken one per cycle while an alignment builds.
//   After the column with last_column set, col.ready stays low while the
//   block sums the right-primer mismatch window (eight columns per cycle),
//   decides, and emits its results through res, one per cycle at most.
//   The window summed before the decision holds W flags, where
//   W = min(right_primer_len, column count, MAX_PRIMER). An alignment of
//   N runs then gives up to N + 3 results (operations, then a summary),
//   or one result marked skipped.
//   res has a single output register: a stalled receiver holds the emission
//   in place, and the next alignment's columns are taken as soon as the last
//   result of the previous one sits in that register.
//   cfg writes left_primer_len (index 0) and right_primer_len (index 1); it
//   is always ready and should be used only while no results are pending.
//   Reset clears both primer lengths, all alignment state and res.valid.
module cigar_edit_distance_builder_unit #(
    parameter int MAX_OPS    = 32,
    parameter int MAX_PRIMER = 256,
    parameter int LEN_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    cedb_chan_if.sink   col,
    cedb_chan_if.sink   cfg,
    cedb_chan_if.source res
);
    import cedb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       col_ready;

    assign col.ready = col_ready;
    assign cfg.ready = 1'b1;

    cedb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_valid (col.valid),
        .col_last  (col.payload.last_column),
        .status    (status),
        .cmd       (cmd),
        .col_ready (col_ready)
    );

    cedb_dp #(
        .MAX_OPS    (MAX_OPS),
        .MAX_PRIMER (MAX_PRIMER),
        .LEN_BITS   (LEN_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .col_data  (col.payload),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.payload),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .res_data  (res.payload)
    );

    // A result is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten while stalled");

    // The final column of an alignment closes the column channel.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (col.valid && col.ready && col.payload.last_column) |=> !col.ready)
        else $error("column accepted during result emission");

    // Alignment state is cleared only together with the final result.
    a_clear_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_align |-> (cmd.out_load && (cmd.emit_sel == EMIT_SUM
                                              || cmd.emit_sel == EMIT_SKIP)))
        else $error("alignment cleared without its final result");

    // The window adder stops once the window is used up.
    a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.win_step |-> !status.win_done)
        else $error("window step past its end");
endmodule

// ===== sv/cedb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cedb_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/cedb_ctrl.sv =====
// Controller of the CIGAR builder: accepts columns, sequences the primer
// window count, the decision and the emission of results.
// Depends on cedb_pkg.
module cedb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   col_valid,
    input  logic                   col_last,
    input  cedb_pkg::dp_status_t   status,
    output cedb_pkg::ctrl_cmd_t    cmd,
    output logic                   col_ready
);
    import cedb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_sel = EMIT_SUM;
        col_ready  = 1'b0;

        unique case (state_reg)
            ST_ACCUM:
            begin
                col_ready = 1'b1;
                if (col_valid)
                begin
                    cmd.col_accept = 1'b1;
                    if (col_last)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.win_start = 1'b1;
                state_next    = ST_WIN;
            end
            ST_WIN:
            begin
                if (status.win_done)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.win_step = 1'b1;
                end
            end
            ST_DECIDE:
            begin
                cmd.latch_dec = 1'b1;
                // Step the store pointer to the first middle entry.
                cmd.idx_inc   = 1'b1;
                state_next    = status.dec_skip ? ST_SKIP : ST_SL;
            end
            ST_SL:
            begin
                cmd.emit_sel = EMIT_SL;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.single)
                    begin
                        state_next = ST_SM;
                    end
                    else if (status.first_m)
                    begin
                        state_next = ST_FM;
                    end
                    else
                    begin
                        state_next = ST_MID;
                    end
                end
            end
            ST_FM:
            begin
                cmd.emit_sel = EMIT_FM;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_MID;
                end
            end
            ST_SM:
            begin
                cmd.emit_sel = EMIT_SM;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_SR;
                end
            end
            ST_MID:
            begin
                cmd.emit_sel = EMIT_MID;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    if (status.mid_last)
                    begin
                        state_next = status.last_m ? ST_LM : ST_SR;
                    end
                end
            end
            ST_LM:
            begin
                cmd.emit_sel = EMIT_LM;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_SR;
                end
            end
            ST_SR:
            begin
                cmd.emit_sel = EMIT_SR;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.emit_sel = EMIT_SUM;
                if (status.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.clear_align = 1'b1;
                    state_next      = ST_ACCUM;
                end
            end
            ST_SKIP:
            begin
                cmd.emit_sel = EMIT_SKIP;
                if (status.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.clear_align = 1'b1;
                    state_next      = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end
endmodule

// ===== sv/cedb_dp.sv =====
// Datapath of the CIGAR builder: run-length coder, operation store, mismatch
// flag shift register, window counter, decision logic and output register.
// Depends on cedb_pkg and cedb_ram.
module cedb_dp #(
    parameter int MAX_OPS    = 32,
    parameter int MAX_PRIMER = 256,
    parameter int LEN_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cedb_pkg::ctrl_cmd_t  cmd,
    output cedb_pkg::dp_status_t status,
    input  cedb_pkg::column_t    col_data,
    input  logic                 cfg_valid,
    input  cedb_pkg::cfg_t       cfg_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output cedb_pkg::result_t    res_data
);
    import cedb_pkg::*;

    localparam int OPC_BITS = $clog2(MAX_OPS + 1);
    localparam int AW       = $clog2(MAX_OPS);
    localparam int WIN_BITS = $clog2(MAX_PRIMER + 1);
    localparam int NCHUNK   = (MAX_PRIMER + 7) / 8;
    localparam int CH_BITS  = NCHUNK > 1 ? $clog2(NCHUNK) : 1;
    localparam int PAD_W    = NCHUNK * 8;
    localparam int XW       = (LEN_BITS > WIN_BITS ? LEN_BITS : WIN_BITS) + 1;
    localparam int ENTRY_W  = LEN_BITS + 2;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    // Configuration registers.
    logic [7:0] lp_reg, lp_next;
    logic [7:0] rp_reg, rp_next;

    // Alignment state.
    logic [LEN_BITS-1:0]   cc_reg, cc_next;
    op_code_t              run_code_reg, run_code_next;
    logic [LEN_BITS-1:0]   run_len_reg, run_len_next;
    logic [OPC_BITS-1:0]   op_count_reg, op_count_next;
    logic [LEN_BITS-1:0]   mt_reg, mt_next;
    logic [LEN_BITS-1:0]   indel_reg, indel_next;
    logic                  ovf_reg, ovf_next;
    logic [MAX_PRIMER-1:0] flags_reg, flags_next;

    // Window count and store pointer.
    logic [WIN_BITS-1:0] rem_reg, rem_next;
    logic [WIN_BITS-1:0] win_reg, win_next;
    logic [CH_BITS-1:0]  chunk_reg, chunk_next;
    logic [AW-1:0]       idx_reg, idx_next;

    // Decision results.
    logic                single_reg, single_next;
    logic                first_m_reg, first_m_next;
    logic                last_m_reg, last_m_next;
    logic [LEN_BITS-1:0] flen_reg, flen_next;
    logic [LEN_BITS-1:0] mm_reg, mm_next;
    logic [LEN_BITS-1:0] ed_reg, ed_next;

    // Output register.
    logic    res_valid_reg, res_valid_next;
    result_t res_data_reg, res_data_next;

    // Store port.
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    // Column decode.
    op_code_t            code;
    logic                cc_full;
    logic [LEN_BITS-1:0] cc_inc;
    logic                new_run;
    logic                push;
    logic                store_ok;
    logic                mm_flag;
    logic [LEN_BITS:0]   indel_sum;

    // Window and decision helpers.
    logic [XW-1:0]       lp_e, rp_e, cc_e, rl_e, fl_e, rem_e, mp_e, w_init, take;
    logic [PAD_W-1:0]    flags_pad;
    logic [7:0]          chunk_bits;
    logic [7:0]          mask;
    logic [2:0]          rem_lo;
    logic [1:0]          f_code;
    logic [LEN_BITS-1:0] f_len;
    logic                skip_single;
    logic                skip_multi;
    logic                too_many;
    logic [LEN_BITS-1:0] mm_val;
    logic [LEN_BITS:0]   ed_sum;
    logic [LEN_BITS-1:0] ed_val;
    logic [XW-1:0]       len_x;

    assign lp_e  = XW'(lp_reg);
    assign rp_e  = XW'(rp_reg);
    assign cc_e  = XW'(cc_reg);
    assign rl_e  = XW'(run_len_reg);
    assign rem_e = XW'(rem_reg);
    assign mp_e  = XW'(MAX_PRIMER);

    cedb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_OPS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    // Configuration writes; indexes outside the list are ignored.
    always_comb
    begin
        lp_next = lp_reg;
        rp_next = rp_reg;
        if (cfg_valid)
        begin
            if (cfg_data.index == CFG_LEFT_PRIMER)
            begin
                lp_next = cfg_data.data;
            end
            else if (cfg_data.index == CFG_RIGHT_PRIMER)
            begin
                rp_next = cfg_data.data;
            end
        end
    end

    // Column decode.
    always_comb
    begin
        if (col_data.query_gap)
        begin
            code = OP_D;
        end
        else if (col_data.ref_gap)
        begin
            code = OP_I;
        end
        else
        begin
            code = OP_M;
        end
        cc_full   = (cc_reg == '1);
        cc_inc    = cc_reg + LEN_BITS'(1);
        new_run   = (cc_reg == '0) || (code != run_code_reg);
        push      = (cc_reg != '0) && (code != run_code_reg);
        store_ok  = op_count_reg < OPC_BITS'(MAX_OPS);
        mm_flag   = !cc_full && (code == OP_M)
                    && (col_data.query_base != col_data.ref_base)
                    && (XW'(cc_inc) > lp_e);
        indel_sum = {1'b0, indel_reg} + {1'b0, run_len_reg};
        ram_we    = cmd.col_accept && !cc_full && push && store_ok;
        ram_wdata = {run_code_reg, run_len_reg};
    end

    // Alignment state update.
    always_comb
    begin
        cc_next       = cc_reg;
        run_code_next = run_code_reg;
        run_len_next  = run_len_reg;
        op_count_next = op_count_reg;
        mt_next       = mt_reg;
        indel_next    = indel_reg;
        ovf_next      = ovf_reg;
        flags_next    = flags_reg;

        priority if (cmd.clear_align)
        begin
            cc_next       = '0;
            run_code_next = OP_M;
            run_len_next  = '0;
            op_count_next = '0;
            mt_next       = '0;
            indel_next    = '0;
            ovf_next      = 1'b0;
            flags_next    = '0;
        end
        else if (cmd.col_accept)
        begin
            if (cc_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cc_next = cc_inc;
                if (new_run)
                begin
                    if (push)
                    begin
                        if (store_ok)
                        begin
                            op_count_next = op_count_reg + OPC_BITS'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (run_code_reg != OP_M)
                        begin
                            indel_next = indel_sum[LEN_BITS] ? '1
                                                             : indel_sum[LEN_BITS-1:0];
                        end
                    end
                    run_code_next = code;
                    run_len_next  = LEN_BITS'(1);
                end
                else
                begin
                    run_len_next = run_len_reg + LEN_BITS'(1);
                end
                if (mm_flag)
                begin
                    mt_next = mt_reg + LEN_BITS'(1);
                end
            end
            // Newest column's flag sits at bit 0.
            flags_next = MAX_PRIMER'({flags_reg, mm_flag});
        end
    end

    // Right-primer window: sum eight flags per cycle, newest first.
    always_comb
    begin
        flags_pad  = PAD_W'(flags_reg);
        chunk_bits = flags_pad[chunk_reg*8 +: 8];
        rem_lo     = 3'(rem_reg);
        if (rem_e >= XW'(8))
        begin
            take = XW'(8);
            mask = 8'hFF;
        end
        else
        begin
            take = rem_e;
            mask = (8'd1 << rem_lo) - 8'd1;
        end
        w_init = (rp_e < cc_e) ? rp_e : cc_e;
        if (w_init > mp_e)
        begin
            w_init = mp_e;
        end

        rem_next   = rem_reg;
        win_next   = win_reg;
        chunk_next = chunk_reg;
        priority if (cmd.win_start)
        begin
            rem_next   = WIN_BITS'(w_init);
            win_next   = '0;
            chunk_next = '0;
        end
        else if (cmd.win_step)
        begin
            rem_next   = WIN_BITS'(rem_e - take);
            win_next   = WIN_BITS'(XW'(win_reg) + XW'(popcount8(chunk_bits & mask)));
            chunk_next = chunk_reg + CH_BITS'(1);
        end
    end

    // Store pointer; the read address is its next value, so the read data
    // always shows the entry the pointer holds.
    always_comb
    begin
        idx_next = idx_reg;
        priority if (cmd.clear_align)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end
    end

    // Decision on the finished alignment.
    always_comb
    begin
        f_code      = ram_rdata[LEN_BITS +: 2];
        f_len       = ram_rdata[LEN_BITS-1:0];
        fl_e        = XW'(f_len);
        too_many    = op_count_reg > OPC_BITS'(MAX_OPS - 2);
        skip_single = (run_code_reg != OP_M) || (rl_e <= lp_e + rp_e);
        skip_multi  = (op_code_t'(f_code) != OP_M) || (fl_e < lp_e)
                      || (run_code_reg != OP_M) || (rl_e < rp_e);
        if (XW'(mt_reg) >= XW'(win_reg))
        begin
            mm_val = LEN_BITS'(XW'(mt_reg) - XW'(win_reg));
        end
        else
        begin
            mm_val = '0;
        end
        ed_sum = {1'b0, mm_val} + {1'b0, indel_reg};
        ed_val = ed_sum[LEN_BITS] ? '1 : ed_sum[LEN_BITS-1:0];

        single_next  = single_reg;
        first_m_next = first_m_reg;
        last_m_next  = last_m_reg;
        flen_next    = flen_reg;
        mm_next      = mm_reg;
        ed_next      = ed_reg;
        if (cmd.latch_dec)
        begin
            single_next  = (op_count_reg == '0);
            first_m_next = fl_e > lp_e;
            last_m_next  = rl_e > rp_e;
            flen_next    = f_len;
            mm_next      = mm_val;
            ed_next      = ed_val;
        end
    end

    always_comb
    begin
        status.win_done = (rem_reg == '0);
        status.dec_skip = ovf_reg || (cc_reg == '0) || too_many
                          || (op_count_reg == OPC_BITS'(1))
                          || ((op_count_reg == '0) ? skip_single : skip_multi);
        status.single   = single_reg;
        status.first_m  = first_m_reg;
        status.last_m   = last_m_reg;
        status.mid_last = (OPC_BITS'(idx_reg) + OPC_BITS'(1)) == op_count_reg;
        status.out_free = !res_valid_reg || res_ready;
    end

    // Result builder and output register.
    always_comb
    begin
        res_data_next = res_data_reg;
        len_x         = '0;
        if (cmd.out_load)
        begin
            res_data_next = '0;
            unique case (cmd.emit_sel)
                EMIT_SL:
                begin
                    res_data_next.op_code = OP_S;
                    len_x = lp_e;
                end
                EMIT_FM:
                begin
                    res_data_next.op_code = OP_M;
                    len_x = XW'(flen_reg) - lp_e;
                end
                EMIT_SM:
                begin
                    res_data_next.op_code = OP_M;
                    len_x = rl_e - lp_e - rp_e;
                end
                EMIT_MID:
                begin
                    res_data_next.op_code = ram_rdata[LEN_BITS +: 2];
                    len_x = XW'(ram_rdata[LEN_BITS-1:0]);
                end
                EMIT_LM:
                begin
                    res_data_next.op_code = OP_M;
                    len_x = rl_e - rp_e;
                end
                EMIT_SR:
                begin
                    res_data_next.op_code = OP_S;
                    len_x = rp_e;
                end
                EMIT_SUM:
                begin
                    res_data_next.edit_distance  = 16'(ed_reg);
                    res_data_next.mismatch_count = 16'(mm_reg);
                    res_data_next.last_result    = 1'b1;
                end
                EMIT_SKIP:
                begin
                    res_data_next.skipped     = 1'b1;
                    res_data_next.last_result = 1'b1;
                end
                default:
                begin
                    res_data_next.last_result = 1'b1;
                end
            endcase
            res_data_next.op_length = 16'(len_x[LEN_BITS-1:0]);
        end

        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg        <= '0;
            rp_reg        <= '0;
            cc_reg        <= '0;
            run_code_reg  <= OP_M;
            run_len_reg   <= '0;
            op_count_reg  <= '0;
            mt_reg        <= '0;
            indel_reg     <= '0;
            ovf_reg       <= 1'b0;
            flags_reg     <= '0;
            rem_reg       <= '0;
            win_reg       <= '0;
            chunk_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            lp_reg        <= lp_next;
            rp_reg        <= rp_next;
            cc_reg        <= cc_next;
            run_code_reg  <= run_code_next;
            run_len_reg   <= run_len_next;
            op_count_reg  <= op_count_next;
            mt_reg        <= mt_next;
            indel_reg     <= indel_next;
            ovf_reg       <= ovf_next;
            flags_reg     <= flags_next;
            rem_reg       <= rem_next;
            win_reg       <= win_next;
            chunk_reg     <= chunk_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        single_reg   <= single_next;
        first_m_reg  <= first_m_next;
        last_m_reg   <= last_m_next;
        flen_reg     <= flen_next;
        mm_reg       <= mm_next;
        ed_reg       <= ed_next;
        res_data_reg <= res_data_next;
    end
endmodule
